>>> src/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bilinear image scaler
// Sizes, request and result payload structs, sequencer states.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int MAX_OUT     = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        frame_end;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIZE_W,
    ST_SIZE_H,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_POS_X,
    ST_POS_Y,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_LERP_INIT,
    ST_LERP,
    ST_ROUND,
    ST_OUT
  } state_t;

endpackage

>>> src/bilinear_image_scaler_core.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_core: bilinear RGB frame scaler
// Loads a source frame into a store and emits scaled pixels on request.
// ----------------------------------------------------------------------------
//  channel   signals                      direction
//  request   in_valid/in_ready/in_data    in   (action + source pixel)
//  result    out_valid/out_ready/out_data out  (position + RGB + frame_end)
//  config    cfg_we/cfg_index/cfg_data    in   (plain write port)
//
// A load is taken in the idle state; the load that completes a frame runs a
// shared restoring divider (one quotient bit per cycle) for both ratios.
// An emit runs these steps: accept, two position products, four reads from the
// single-port frame store, eighteen products on one multiplier (three lerps
// per channel), then the result step. Reset is synchronous; the store is not
// cleared. A held result stalls only a finished emit in its result step.
module bilinear_image_scaler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bis_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bis_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]      cfg_data
);

  logic [9:0]  source_width, source_height;
  logic [12:0] scale_factor;
  logic [17:0] load_count;
  logic [11:0] emit_col, emit_row;
  logic [31:0] col_ratio, row_ratio;
  logic [12:0] dest_width, dest_height;

  bis_pkg::state_t state, state_next;

  logic [23:0] frame_store [bis_pkg::STORE_DEPTH];
  logic [23:0] rd_data;
  logic [bis_pkg::ADDR_W-1:0] mem_addr;
  logic        mem_we;

  // datapath registers
  logic [47:0] div_rem;       // dividend shifter / remainder
  logic [31:0] div_q;
  logic [5:0]  div_cnt;
  logic        div_axis;      // 0 column, 1 row
  logic [9:0]  xl, yl, xh, yh;
  logic [7:0]  wx, wy;
  logic [23:0] pa, pb, pc, pd;
  logic [2:0]  lerp_ch;
  logic [1:0]  lerp_ph;
  logic [15:0] ab, cd;
  logic [23:0] vacc;
  logic [7:0]  res_r, res_g, res_b;
  logic        last;
  bis_pkg::out_item_t out_reg;
  logic        out_full;

  // effective dimensions
  logic [9:0] w_eff, h_eff;
  always_comb begin
    w_eff = (source_width == 10'd0) ? 10'd1 :
            (source_width > 10'(bis_pkg::MAX_WIDTH)) ? 10'(bis_pkg::MAX_WIDTH) : source_width;
    h_eff = (source_height == 10'd0) ? 10'd1 :
            (source_height > 10'(bis_pkg::MAX_HEIGHT)) ? 10'(bis_pkg::MAX_HEIGHT)
                                                       : source_height;
  end

  logic [19:0] frame_px;
  assign frame_px = w_eff * h_eff;

  logic [17:0] load_count_inc;
  assign load_count_inc = load_count + 18'd1;

  logic accept;
  assign in_ready = (state == bis_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // output register is free to take a new result
  logic out_free;
  assign out_free = !out_full || out_ready;

  // shared multiplier: one product per cycle
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic [7:0]  ch_a, ch_b, ch_c, ch_d;
  always_comb begin
    unique case (lerp_ch)
      3'd0:    begin ch_a = pa[23:16]; ch_b = pb[23:16]; ch_c = pc[23:16]; ch_d = pd[23:16]; end
      3'd1:    begin ch_a = pa[15:8];  ch_b = pb[15:8];  ch_c = pc[15:8];  ch_d = pd[15:8];  end
      default: begin ch_a = pa[7:0];   ch_b = pb[7:0];   ch_c = pc[7:0];   ch_d = pd[7:0];   end
    endcase
  end

  logic [8:0] wx_c, wy_c;
  assign wx_c = 9'd256 - {1'b0, wx};
  assign wy_c = 9'd256 - {1'b0, wy};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      bis_pkg::ST_SIZE_W: begin mul_a = {22'd0, w_eff}; mul_b = {3'd0, scale_factor}; end
      bis_pkg::ST_SIZE_H: begin mul_a = {22'd0, h_eff}; mul_b = {3'd0, scale_factor}; end
      bis_pkg::ST_POS_X:  begin mul_a = col_ratio; mul_b = {4'd0, emit_col}; end
      bis_pkg::ST_POS_Y:  begin mul_a = row_ratio; mul_b = {4'd0, emit_row}; end
      bis_pkg::ST_LERP: begin
        unique case (lerp_ph)
          2'd0:    begin mul_a = {24'd0, ch_a}; mul_b = {7'd0, wx_c}; end
          2'd1:    begin mul_a = {24'd0, ch_b}; mul_b = {8'd0, wx};   end
          2'd2:    begin mul_a = {24'd0, ch_c}; mul_b = {7'd0, wx_c}; end
          default: begin mul_a = {24'd0, ch_d}; mul_b = {8'd0, wx};   end
        endcase
      end
      bis_pkg::ST_ROUND: begin
        mul_a = {16'd0, ab};
        mul_b = (lerp_ph == 2'd0) ? {7'd0, wy_c} : {8'd0, wy};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // saturated scaled size
  logic [47:0] size_raw;
  logic [12:0] size_sat;
  assign size_raw = (mul_p + 48'd128) >> 8;
  assign size_sat = (size_raw > 48'(bis_pkg::MAX_OUT)) ? 13'(bis_pkg::MAX_OUT) : size_raw[12:0];

  // divider operands for current axis
  logic [12:0] div_out;
  logic [9:0]  div_in;
  logic [12:0] div_d;
  assign div_out = div_axis ? dest_height : dest_width;
  assign div_in  = div_axis ? h_eff : w_eff;
  assign div_d   = div_out - 13'd1;

  logic [48:0] div_trial;
  assign div_trial = {div_rem, div_q[31]} - {36'd0, div_d};

  // position split
  logic [47:0] pos;
  logic [9:0]  lo_clamp, hi_clamp, dim_m1;
  assign pos = mul_p;
  assign dim_m1 = (state == bis_pkg::ST_POS_X) ? (w_eff - 10'd1) : (h_eff - 10'd1);
  assign lo_clamp = (pos[47:16] > {22'd0, dim_m1}) ? dim_m1 : pos[25:16];
  assign hi_clamp = (lo_clamp + 10'd1 > dim_m1) ? dim_m1 : lo_clamp + 10'd1;

  // frame store address
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = load_count[bis_pkg::ADDR_W-1:0];
    unique case (state)
      bis_pkg::ST_IDLE: mem_we = accept && (in_data.action == bis_pkg::ACT_LOAD);
      bis_pkg::ST_RD_A: mem_addr = bis_pkg::ADDR_W'({8'd0, yl} * {8'd0, w_eff} + {8'd0, xl});
      bis_pkg::ST_RD_B: mem_addr = bis_pkg::ADDR_W'({8'd0, yl} * {8'd0, w_eff} + {8'd0, xh});
      bis_pkg::ST_RD_C: mem_addr = bis_pkg::ADDR_W'({8'd0, yh} * {8'd0, w_eff} + {8'd0, xl});
      bis_pkg::ST_RD_D: mem_addr = bis_pkg::ADDR_W'({8'd0, yh} * {8'd0, w_eff} + {8'd0, xh});
      default: ;
    endcase
  end

  // single-port frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_addr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    rd_data <= frame_store[mem_addr];
  end

  logic emit_ok;
  assign emit_ok = (dest_width != 13'd0) && (dest_height != 13'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bis_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.action == bis_pkg::ACT_LOAD) begin
            if ({2'd0, load_count_inc} >= frame_px || load_count_inc == 18'd0) begin
              state_next = bis_pkg::ST_SIZE_W;
            end
          end else if (emit_ok) begin
            state_next = bis_pkg::ST_POS_X;
          end
        end
      end
      bis_pkg::ST_SIZE_W:   state_next = bis_pkg::ST_SIZE_H;
      bis_pkg::ST_SIZE_H:   state_next = bis_pkg::ST_DIV_INIT;
      bis_pkg::ST_DIV_INIT: state_next = bis_pkg::ST_DIV_RUN;
      bis_pkg::ST_DIV_RUN: begin
        if (div_cnt == 6'd0) begin
          state_next = div_axis ? bis_pkg::ST_IDLE : bis_pkg::ST_DIV_INIT;
        end
      end
      bis_pkg::ST_POS_X:    state_next = bis_pkg::ST_POS_Y;
      bis_pkg::ST_POS_Y:    state_next = bis_pkg::ST_RD_A;
      bis_pkg::ST_RD_A:     state_next = bis_pkg::ST_RD_B;
      bis_pkg::ST_RD_B:     state_next = bis_pkg::ST_RD_C;
      bis_pkg::ST_RD_C:     state_next = bis_pkg::ST_RD_D;
      bis_pkg::ST_RD_D:     state_next = bis_pkg::ST_LERP_INIT;
      bis_pkg::ST_LERP_INIT: state_next = bis_pkg::ST_LERP;
      bis_pkg::ST_LERP:     if (lerp_ph == 2'd3) state_next = bis_pkg::ST_ROUND;
      bis_pkg::ST_ROUND: begin
        if (lerp_ph == 2'd1) begin
          state_next = (lerp_ch == 3'd2) ? bis_pkg::ST_OUT : bis_pkg::ST_LERP;
        end
      end
      bis_pkg::ST_OUT:      state_next = out_free ? bis_pkg::ST_IDLE : bis_pkg::ST_OUT;
      default:              state_next = bis_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bis_pkg::ST_IDLE;
      source_width  <= 10'd512;
      source_height <= 10'd512;
      scale_factor  <= 13'd256;
      load_count    <= '0;
      emit_col      <= '0;
      emit_row      <= '0;
      col_ratio     <= '0;
      row_ratio     <= '0;
      dest_width    <= '0;
      dest_height   <= '0;
      out_full      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          bis_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[9:0];
          bis_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[9:0];
          bis_pkg::REG_SCALE_FACTOR:  scale_factor  <= cfg_data;
          default: ;
        endcase
      end
      // set on a finished pixel, drop when taken
      if (state == bis_pkg::ST_OUT && out_free) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
      unique case (state)
        bis_pkg::ST_IDLE: begin
          if (accept && in_data.action == bis_pkg::ACT_LOAD) begin
            load_count <= load_count_inc;
          end else if (accept && emit_ok) begin
            if ({1'b0, emit_col} >= dest_width || {1'b0, emit_row} >= dest_height) begin
              emit_col <= '0;
              emit_row <= '0;
            end
          end
        end
        bis_pkg::ST_SIZE_W: dest_width <= size_sat;
        bis_pkg::ST_SIZE_H: begin
          dest_height <= size_sat;
          emit_col    <= '0;
          emit_row    <= '0;
          load_count  <= '0;
        end
        bis_pkg::ST_DIV_RUN: begin
          if (div_cnt == 6'd0) begin
            if (div_out <= 13'd1) begin
              if (div_axis) row_ratio <= '0; else col_ratio <= '0;
            end else begin
              if (div_axis) row_ratio <= div_q; else col_ratio <= div_q;
            end
          end
        end
        bis_pkg::ST_OUT: begin
          if (out_free) begin
            if (last) begin
              emit_col <= '0;
              emit_row <= '0;
            end else if ({1'b0, emit_col} + 13'd1 >= dest_width) begin
              emit_col <= '0;
              emit_row <= emit_row + 12'd1;
            end else begin
              emit_col <= emit_col + 12'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] sat8(input logic [23:0] v);
    logic [24:0] r;
    r = {1'b0, v} + 25'd32768;
    return (r[24:16] > 9'(bis_pkg::PIX_MAX)) ? bis_pkg::PIX_MAX : r[23:16];
  endfunction

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bis_pkg::ST_SIZE_H: div_axis <= 1'b0;
      bis_pkg::ST_DIV_INIT: begin
        // dividend ((in-1)<<16) + d/2, fed one bit a step from div_q
        div_q   <= ({6'd0, div_in - 10'd1, 16'd0}) + {20'd0, div_d[12:1]};
        div_rem <= '0;
        div_cnt <= 6'd32;
      end
      bis_pkg::ST_DIV_RUN: begin
        if (div_cnt == 6'd0) begin
          div_axis <= 1'b1;
        end else begin
          if (!div_trial[48]) begin
            div_rem <= div_trial[47:0];
            div_q   <= {div_q[30:0], 1'b1};
          end else begin
            div_rem <= {div_rem[46:0], div_q[31]};
            div_q   <= {div_q[30:0], 1'b0};
          end
          div_cnt <= div_cnt - 6'd1;
        end
      end
      bis_pkg::ST_POS_X: begin
        xl <= lo_clamp; xh <= hi_clamp; wx <= pos[15:8];
        last <= ({1'b0, emit_col} == dest_width - 13'd1) &&
                ({1'b0, emit_row} == dest_height - 13'd1);
      end
      bis_pkg::ST_POS_Y: begin
        yl <= lo_clamp; yh <= hi_clamp; wy <= pos[15:8];
      end
      bis_pkg::ST_RD_B: pa <= rd_data;
      bis_pkg::ST_RD_C: pb <= rd_data;
      bis_pkg::ST_RD_D: pc <= rd_data;
      bis_pkg::ST_LERP_INIT: begin
        pd <= rd_data; lerp_ch <= '0; lerp_ph <= '0;
      end
      bis_pkg::ST_LERP: begin
        unique case (lerp_ph)
          2'd0:    ab <= mul_p[15:0];
          2'd1:    ab <= ab + mul_p[15:0];
          2'd2:    cd <= mul_p[15:0];
          default: cd <= cd + mul_p[15:0];
        endcase
        lerp_ph <= (lerp_ph == 2'd3) ? 2'd0 : lerp_ph + 2'd1;
      end
      bis_pkg::ST_ROUND: begin
        if (lerp_ph == 2'd0) begin
          vacc    <= mul_p[23:0];
          ab      <= cd;
          wy      <= wy;
          lerp_ph <= 2'd1;
        end else begin
          // ab now holds cd; add cd*wy, round, clamp
          unique case (lerp_ch)
            3'd0:    res_r <= sat8(vacc + mul_p[23:0]);
            3'd1:    res_g <= sat8(vacc + mul_p[23:0]);
            default: res_b <= sat8(vacc + mul_p[23:0]);
          endcase
          lerp_ch <= lerp_ch + 3'd1;
          lerp_ph <= 2'd0;
        end
      end
      bis_pkg::ST_OUT: begin
        if (out_free) begin
          out_reg.out_col   <= emit_col;
          out_reg.out_row   <= emit_row;
          out_reg.red_out   <= res_r;
          out_reg.green_out <= res_g;
          out_reg.blue_out  <= res_b;
          out_reg.frame_end <= last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_full;
  assign out_data  = out_reg;

`ifndef SYNTHESIS
  // a finished pixel waits while the held result is not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == bis_pkg::ST_OUT && out_full && !out_ready |=> state == bis_pkg::ST_OUT)
    else $error("held result overwritten");
  // a held result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held result changed");
  // results only come from the emit sequence
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state) == bis_pkg::ST_OUT)
    else $error("result outside emit path");
`endif

endmodule
